// File: rtl/bcw3_pkg.sv
`timescale 1ns / 1ps

package bcw3_pkg;

    // Field widths of one transaction
    localparam int COORD_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_BITS      = 32;

    // Internal widths, all exact for any coordinate value
    localparam int EDGE_W = COORD_BITS + 1;      // difference of two coordinates
    localparam int SQ_W   = 2 * EDGE_W;          // one coordinate product
    localparam int DOT_W  = SQ_W + 1;            // sum of three products
    localparam int HALF_W = (DOT_W + 1) / 2;     // low slice of a split multiply
    localparam int HI_W   = DOT_W - HALF_W;      // high slice of a split multiply
    localparam int PROD_W = 2 * DOT_W;           // product of two dot products
    localparam int NUM_W  = PROD_W + 1;          // difference of two such products

    // Divider: one quotient bit per stage, plus input, setup and output stages
    localparam int QUO_W    = WEIGHT_BITS;
    localparam int DIV_LAT  = QUO_W + 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
    } t_in_item;

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] weight_a;
        logic signed [WEIGHT_BITS-1:0] weight_b;
        logic signed [WEIGHT_BITS-1:0] weight_c;
        logic                          degenerate;
        logic                          saturated;
    } t_out_item;

    // Partial products of a split dot-product multiply
    typedef struct packed {
        logic signed [2*HI_W-1:0]      hh;
        logic signed [HI_W+HALF_W:0]   hl;
        logic signed [HI_W+HALF_W:0]   lh;
        logic        [2*HALF_W-1:0]    ll;
    } t_part;

    // Form the four partial products of a * b
    function automatic t_part part_mul(input logic signed [DOT_W-1:0] a,
                                       input logic signed [DOT_W-1:0] b);
        t_part                   p;
        logic signed [HI_W-1:0]  ah;
        logic signed [HI_W-1:0]  bh;
        logic signed [HALF_W:0]  al;
        logic signed [HALF_W:0]  bl;
        ah   = a[DOT_W-1:HALF_W];
        bh   = b[DOT_W-1:HALF_W];
        al   = {1'b0, a[HALF_W-1:0]};
        bl   = {1'b0, b[HALF_W-1:0]};
        p.hh = ah * bh;
        p.hl = ah * bl;
        p.lh = al * bh;
        p.ll = a[HALF_W-1:0] * b[HALF_W-1:0];
        return p;
    endfunction

    // Recombine the partial products into the full product
    function automatic logic signed [PROD_W-1:0] part_sum(input t_part p);
        logic signed [PROD_W-1:0] s_hh;
        logic signed [PROD_W-1:0] s_hl;
        logic signed [PROD_W-1:0] s_lh;
        logic signed [PROD_W-1:0] s_ll;
        s_hh = PROD_W'($signed(p.hh));
        s_hl = PROD_W'($signed(p.hl));
        s_lh = PROD_W'($signed(p.lh));
        s_ll = $signed(PROD_W'(p.ll));
        return (s_hh <<< (2 * HALF_W)) + ((s_hl + s_lh) <<< HALF_W) + s_ll;
    endfunction

endpackage

// File: rtl/bcw3_div.sv
`timescale 1ns / 1ps

module bcw3_div #(
    parameter int WEIGHT_FRAC_BITS = bcw3_pkg::WEIGHT_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [bcw3_pkg::NUM_W-1:0]    i_num,
    input  logic        [bcw3_pkg::NUM_W-1:0]    i_den,
    output logic signed [bcw3_pkg::QUO_W-1:0]    o_quo,
    output logic                                 o_sat
);

    localparam int NW = bcw3_pkg::NUM_W;
    localparam int QW = bcw3_pkg::QUO_W;
    localparam int RW = NW + QW + WEIGHT_FRAC_BITS;

    logic          r_neg0;
    logic [NW-1:0] r_mag0;
    logic [NW-1:0] r_den0;

    logic [RW-1:0] r_rem [QW];
    logic [NW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_neg [QW+1];
    logic          r_ovf [QW+1];

    logic [RW-1:0] w_dvd;
    logic [QW-1:0] w_q;
    logic          n_sat;
    logic [QW-1:0] n_quo;

    // Take the magnitude of the numerator
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0 <= i_num[NW-1];
            r_mag0 <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_den0 <= i_den;
        end
    end

    // Scale the dividend and flag a quotient that cannot fit the quotient width
    assign w_dvd = RW'(r_mag0) << WEIGHT_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_dvd;
            r_den[0] <= r_den0;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg0;
            r_ovf[0] <= w_dvd >= (RW'(r_den0) << QW);
        end
    end

    // Restoring division, one quotient bit per stage, most significant first
    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int K = QW - 1 - s;
        logic [RW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = RW'(r_den[s]) << K;
        assign w_ge = r_rem[s] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1]   <= r_q[s] | (w_ge ? (QW'(1) << K) : '0);
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end

        if (s < QW - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= w_ge ? (r_rem[s] - w_sh) : r_rem[s];
                    r_den[s+1] <= r_den[s];
                end
            end
        end
    end

    // Apply the sign and clamp to the signed range
    assign w_q = r_q[QW];

    always_comb begin
        if (r_neg[QW]) begin
            n_sat = r_ovf[QW] || (w_q > (QW'(1) << (QW - 1)));
            n_quo = n_sat ? (QW'(1) << (QW - 1)) : QW'(-w_q);
        end else begin
            n_sat = r_ovf[QW] || w_q[QW-1];
            n_quo = n_sat ? ((QW'(1) << (QW - 1)) - QW'(1)) : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo <= $signed(n_quo);
            o_sat <= n_sat;
        end
    end

endmodule

// File: rtl/barycentric_weights_3d_core.sv
`timescale 1ns / 1ps

// Channel   Valid        Stall         Payload                 Direction
// input     i_in_valid   o_in_stall    i_in_data  (t_in_item)  into the core
// output    o_out_valid  i_out_stall   o_out_data (t_out_item) out of the core
//
// One transaction enters per cycle while the input is not stalled; each result passes
// six arithmetic stages, 35 divider stages and one output register.
// The divider depth of one stage per quotient bit sets the latency.
// Reset clears only the valid bits; no clearing pass is needed.
// A stall on the output freezes the whole pipeline; with the output register
// empty or moving, input is taken even while results wait downstream.

module barycentric_weights_3d_core #(
    parameter int WEIGHT_FRAC_BITS = bcw3_pkg::WEIGHT_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bcw3_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bcw3_pkg::t_out_item o_out_data
);

    localparam int CB    = bcw3_pkg::COORD_BITS;
    localparam int EW    = bcw3_pkg::EDGE_W;
    localparam int SW    = bcw3_pkg::SQ_W;
    localparam int DW    = bcw3_pkg::DOT_W;
    localparam int PW    = bcw3_pkg::PROD_W;
    localparam int NW    = bcw3_pkg::NUM_W;
    localparam int WB    = bcw3_pkg::WEIGHT_BITS;
    localparam int DL    = bcw3_pkg::DIV_LAT;
    localparam int SUM_W = WB + 2;
    localparam logic signed [SUM_W-1:0] WMAX = (SUM_W'(1) <<< (WB - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] WMIN = -(SUM_W'(1) <<< (WB - 1));

    logic en;

    logic signed [CB-1:0] w_a [3];
    logic signed [CB-1:0] w_b [3];
    logic signed [CB-1:0] w_c [3];
    logic signed [CB-1:0] w_p [3];

    logic [5:0]    r_v;
    logic [DL-1:0] r_vd;
    logic [DL-1:0] r_dg;

    logic signed [EW-1:0] r_e0 [3];
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];

    logic signed [SW-1:0] r_sq00 [3];
    logic signed [SW-1:0] r_sq01 [3];
    logic signed [SW-1:0] r_sq11 [3];
    logic signed [SW-1:0] r_sq20 [3];
    logic signed [SW-1:0] r_sq21 [3];

    logic signed [DW-1:0] r_d00;
    logic signed [DW-1:0] r_d01;
    logic signed [DW-1:0] r_d11;
    logic signed [DW-1:0] r_d20;
    logic signed [DW-1:0] r_d21;

    bcw3_pkg::t_part      r_pa [6];
    logic signed [PW-1:0] r_pp [6];

    logic [NW-1:0]        r_den;
    logic signed [NW-1:0] r_nb;
    logic signed [NW-1:0] r_nc;
    logic                 r_degen;

    logic signed [WB-1:0] w_wb;
    logic signed [WB-1:0] w_wc;
    logic                 w_sat_b;
    logic                 w_sat_c;

    logic signed [SUM_W-1:0] w_wa;
    bcw3_pkg::t_out_item     n_out;
    logic                    r_out_valid;
    bcw3_pkg::t_out_item     r_out;

    // Advance the pipeline unless a held result is stalled
    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_a = '{i_in_data.ax, i_in_data.ay, i_in_data.az};
    assign w_b = '{i_in_data.bx, i_in_data.by, i_in_data.bz};
    assign w_c = '{i_in_data.cx, i_in_data.cy, i_in_data.cz};
    assign w_p = '{i_in_data.px, i_in_data.py, i_in_data.pz};

    // Carry valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vd <= '0;
        end else if (en) begin
            r_v  <= {r_v[4:0], i_in_valid};
            r_vd <= {r_vd[DL-2:0], r_v[5]};
        end
    end

    // Form edge vectors, then per-axis products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_e0[k]   <= EW'(w_b[k]) - EW'(w_a[k]);
                r_e1[k]   <= EW'(w_c[k]) - EW'(w_a[k]);
                r_e2[k]   <= EW'(w_p[k]) - EW'(w_a[k]);
                r_sq00[k] <= r_e0[k] * r_e0[k];
                r_sq01[k] <= r_e0[k] * r_e1[k];
                r_sq11[k] <= r_e1[k] * r_e1[k];
                r_sq20[k] <= r_e2[k] * r_e0[k];
                r_sq21[k] <= r_e2[k] * r_e1[k];
            end
        end
    end

    // Sum the dot products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d00 <= DW'(r_sq00[0]) + DW'(r_sq00[1]) + DW'(r_sq00[2]);
            r_d01 <= DW'(r_sq01[0]) + DW'(r_sq01[1]) + DW'(r_sq01[2]);
            r_d11 <= DW'(r_sq11[0]) + DW'(r_sq11[1]) + DW'(r_sq11[2]);
            r_d20 <= DW'(r_sq20[0]) + DW'(r_sq20[1]) + DW'(r_sq20[2]);
            r_d21 <= DW'(r_sq21[0]) + DW'(r_sq21[1]) + DW'(r_sq21[2]);
        end
    end

    // Split multiplies for the denominator and both numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa[0] <= bcw3_pkg::part_mul(r_d00, r_d11);
            r_pa[1] <= bcw3_pkg::part_mul(r_d01, r_d01);
            r_pa[2] <= bcw3_pkg::part_mul(r_d11, r_d20);
            r_pa[3] <= bcw3_pkg::part_mul(r_d01, r_d21);
            r_pa[4] <= bcw3_pkg::part_mul(r_d00, r_d21);
            r_pa[5] <= bcw3_pkg::part_mul(r_d01, r_d20);
            for (int j = 0; j < 6; j++) begin
                r_pp[j] <= bcw3_pkg::part_sum(r_pa[j]);
            end
        end
    end

    // Form denominator and numerators; a zero denominator marks a flat triangle
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den   <= NW'(r_pp[0]) - NW'(r_pp[1]);
            r_nb    <= NW'(r_pp[2]) - NW'(r_pp[3]);
            r_nc    <= NW'(r_pp[4]) - NW'(r_pp[5]);
            r_degen <= r_pp[0] == r_pp[1];
            r_dg    <= {r_dg[DL-2:0], r_degen};
        end
    end

    bcw3_div #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_nb),
        .i_den (r_den),
        .o_quo (w_wb),
        .o_sat (w_sat_b)
    );

    bcw3_div #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_div_c (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_nc),
        .i_den (r_den),
        .o_quo (w_wc),
        .o_sat (w_sat_c)
    );

    // Derive the first weight, clamp it, and zero the weights for a flat triangle
    assign w_wa = (SUM_W'(1) <<< WEIGHT_FRAC_BITS) - SUM_W'(w_wb) - SUM_W'(w_wc);

    always_comb begin
        n_out = '0;
        if (r_dg[DL-1]) begin
            n_out.degenerate = 1'b1;
        end else begin
            n_out.weight_b  = w_wb;
            n_out.weight_c  = w_wc;
            n_out.saturated = w_sat_b || w_sat_c || (w_wa > WMAX) || (w_wa < WMIN);
            if (w_wa > WMAX) begin
                n_out.weight_a = WB'(WMAX);
            end else if (w_wa < WMIN) begin
                n_out.weight_a = WB'(WMIN);
            end else begin
                n_out.weight_a = WB'(w_wa);
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vd[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |->
            (o_out_data.weight_a == '0 && o_out_data.weight_b == '0 &&
             o_out_data.weight_c == '0 && !o_out_data.saturated))
        else $error("flat triangle result carries non-zero weights");

    a_sum_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.degenerate && !o_out_data.saturated) |->
            (WB'(o_out_data.weight_a + o_out_data.weight_b + o_out_data.weight_c)
                == WB'(SUM_W'(1) <<< WEIGHT_FRAC_BITS)))
        else $error("unclamped weights do not sum to one");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow the held result");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");

endmodule
